>>> rtl/pal_pkg.sv
package pal_pkg;

    localparam int POS_WIDTH = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int LEN_WIDTH = 7;
    localparam int REQ_WIDTH = 2;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_GET    = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_UPDATE = 2'd3
    } pal_req_t;

    // broadcast to every cell; idx is the 0-based target position
    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic                 upd;
        logic [POS_WIDTH-1:0] idx;
    } pal_cmd_t;

endpackage

>>> rtl/pal_cell.sv
module pal_cell
    import pal_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  pal_cmd_t              cmd,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam bit BEYOND = INDEX > ((1 << POS_WIDTH) - 2);
    localparam logic [POS_WIDTH-1:0] IDX = POS_WIDTH'(INDEX);

    logic                  at_idx;
    logic                  above_idx;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    assign at_idx    = !BEYOND && (IDX == cmd.idx);
    assign above_idx = BEYOND || (IDX > cmd.idx);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (above_idx)
                data_next = left_data;
            else if (at_idx)
                data_next = wdata;
        end
        else if (cmd.del)
        begin
            if (above_idx || at_idx)
                data_next = right_data;
        end
        else if (cmd.upd)
        begin
            if (at_idx)
                data_next = wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = at_idx ? data_reg : '0;

endmodule

>>> rtl/positional_array_list.sv
// Positional list of up to CAPACITY entries, addressed by 1-based position.
// Input channel s_axis: tuser carries the request kind (get, insert before,
// delete, update), tdata carries the position and the write value.
// Output channel m_axis: one transfer per request; tuser is the status
// (0 ok, 1 error), tdata the value read or removed (zero otherwise), the
// length after the request and an empty flag.
// Every entry lives in its own cell of a row; insert and delete move all
// cells toward their neighbor at once, so the result is registered and
// appears in the cycle after the input transfer, and a new request can be
// taken every cycle while the receiver keeps taking results.
// The result register stalls the input only while it holds a result that
// the receiver has not taken; s_axis_tready is high when the register is
// empty or is being drained in the same cycle.
// Reset empties the list and drops any pending result; entry contents are
// not cleared and are never read before being written.
// A bad position, or an insert into a full list, returns status 1 and
// leaves the list unchanged.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[7:0], value[39:8]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // read_value[31:0], list_length[38:32], is_empty[39]
    output logic        m_axis_tuser   // status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_WIDTH) ? CW : POS_WIDTH) + 1;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    logic                   status_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic [CW-1:0]          len_reg;

    logic                         accept;
    pal_req_t                     req;
    logic [POS_WIDTH-1:0]         position;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0]        wdata;
    logic [CMPW-1:0]              pos_w;
    logic [CMPW-1:0]              cnt_w;
    logic                         full;
    logic                         bad_pos;
    logic                         bad_ins;
    logic                         err;
    pal_cmd_t                     cmd;
    logic [DATA_WIDTH-1:0]        sel_data;
    logic [VALUE_WIDTH-1:0]       rd_value;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign req      = pal_req_t'(s_axis_tuser);
    assign position = s_axis_tdata[POS_WIDTH-1:0];
    assign value    = signed'(s_axis_tdata[POS_WIDTH +: VALUE_WIDTH]);
    assign wdata    = DATA_WIDTH'(value);

    assign pos_w   = CMPW'(position);
    assign cnt_w   = CMPW'(count_reg);
    assign full    = count_reg == CW'(CAPACITY);
    assign bad_pos = (position == '0) || (pos_w > cnt_w);
    assign bad_ins = (position == '0) || (pos_w > cnt_w + CMPW'(1)) || full;

    always_comb
    begin
        cmd.ins    = 1'b0;
        cmd.del    = 1'b0;
        cmd.upd    = 1'b0;
        cmd.idx    = position - POS_WIDTH'(1);
        err        = bad_pos;
        count_next = count_reg;
        case (req)
            REQ_GET:
            begin
                err = bad_pos;
            end
            REQ_INSERT:
            begin
                err     = bad_ins;
                cmd.ins = accept && !bad_ins;
                if (!bad_ins)
                    count_next = count_reg + CW'(1);
            end
            REQ_DELETE:
            begin
                err     = bad_pos;
                cmd.del = accept && !bad_pos;
                if (!bad_pos)
                    count_next = count_reg - CW'(1);
            end
            REQ_UPDATE:
            begin
                err     = bad_pos;
                cmd.upd = accept && !bad_pos;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wdata      (wdata),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++)
            sel_data = sel_data | cell_tap[i];
    end

    always_comb
    begin
        rd_value = '0;
        if (!err && (req == REQ_GET || req == REQ_DELETE))
            rd_value = VALUE_WIDTH'(signed'(sel_data));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= err;
            rdata_reg  <= rd_value;
            len_reg    <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {len_reg == '0, LEN_WIDTH'(len_reg), rdata_reg};

endmodule
